/* hdl/frred_pkg.sv */
package frred_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

    // top level to engine
    typedef struct packed {
        logic start;
        logic take;
    } t_eng_ctl;

    // engine to top level
    typedef struct packed {
        logic idle;
        logic done;
        logic invalid;
        logic is_whole;
    } t_eng_sts;

endpackage

/* hdl/fraction_reducer_core.sv */
// channel | dir | tdata (low bit up)                           | tuser (low bit up)
// s_axis  | in  | numerator, denominator, zero pad to bytes     | -
// m_axis  | out | reduced_numerator, reduced_denominator, pad   | is_whole, invalid
//
// One request at a time. A binary gcd loop on one shared subtractor runs
// first, then two restoring divisions divide the numerator and the denominator
// by the gcd; a zero input skips both and is flagged invalid.
// Synchronous active-low reset clears the sequencer and the output valid.
// A finished result waits in the output register; the next request is taken
// while it waits, and the engine holds its own result if the register is full.
module fraction_reducer_core
    import frred_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // numerator, denominator
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // reduced_numerator, reduced_denominator
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // is_whole, invalid
    output logic [1:0]                             m_axis_tuser
);

    localparam int W       = VALUE_WIDTH;
    localparam int TDATA_W = ((2*VALUE_WIDTH+7)/8)*8;

    t_eng_ctl     eng_ctl;
    t_eng_sts     eng_sts;
    logic [W-1:0] eng_rnum, eng_rden;

    logic               r_ovalid, n_ovalid;
    logic [TDATA_W-1:0] r_otdata, n_otdata;
    logic [1:0]         r_otuser, n_otuser;

    assign eng_ctl.start = s_axis_tvalid && eng_sts.idle;
    assign eng_ctl.take  = eng_sts.done && (!r_ovalid || m_axis_tready);

    frred_engine #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_num   (s_axis_tdata[W-1:0]),
        .i_den   (s_axis_tdata[2*W-1:W]),
        .o_sts   (eng_sts),
        .o_rnum  (eng_rnum),
        .o_rden  (eng_rden)
    );

    always_comb begin
        n_ovalid = r_ovalid;
        n_otdata = r_otdata;
        n_otuser = r_otuser;
        if (eng_ctl.take) begin
            n_ovalid = 1'b1;
            n_otdata = TDATA_W'({eng_rden, eng_rnum});
            n_otuser = {eng_sts.invalid, eng_sts.is_whole};
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_otdata <= n_otdata;
        r_otuser <= n_otuser;
    end

    assign s_axis_tready = eng_sts.idle;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;
    assign m_axis_tuser  = r_otuser;

`ifndef NO_ASSERTIONS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine took a request without going busy");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("invalid result carries data");

    a_whole_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[2*W-1:W] == W'(1))
        else $error("whole flag without unit denominator");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1]
            |-> m_axis_tdata[W-1:0] != '0 && m_axis_tdata[2*W-1:W] != '0)
        else $error("zero term in a valid result");
`endif

endmodule

/* hdl/frred_engine.sv */
module frred_engine
    import frred_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_eng_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_num,
    input  logic [VALUE_WIDTH-1:0] i_den,
    output t_eng_sts               o_sts,
    output logic [VALUE_WIDTH-1:0] o_rnum,
    output logic [VALUE_WIDTH-1:0] o_rden
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    t_state r_state, n_state;

    logic [W-1:0]     r_a, n_a;
    logic [W-1:0]     r_b, n_b;
    logic [W-1:0]     r_n, n_n;
    logic [W-1:0]     r_d, n_d;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_q, n_q;
    logic [W-1:0]     r_rn, n_rn;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_inv, n_inv;

    // shared subtractor: compare for the gcd loop and the division steps
    logic [W+1:0] sub_a, sub_b, sub_diff;
    logic         sub_borrow;
    logic [W-1:0] gcd_odd;
    logic [W:0]   rem_sh;

    assign gcd_odd    = r_a | r_b;
    assign rem_sh     = {r_rem, r_q[W-1]};
    assign sub_diff   = sub_a - sub_b;
    assign sub_borrow = sub_diff[W+1];

    always_comb begin
        if (r_state == S_GCD) begin
            sub_a = {2'b00, r_a};
            sub_b = {2'b00, r_b};
        end else begin
            sub_a = {1'b0, rem_sh};
            sub_b = {2'b00, gcd_odd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_n   <= n_n;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_rn  <= n_rn;
        r_cnt <= n_cnt;
        r_inv <= n_inv;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_n     = r_n;
        n_d     = r_d;
        n_rem   = r_rem;
        n_q     = r_q;
        n_rn    = r_rn;
        n_cnt   = r_cnt;
        n_inv   = r_inv;

        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    n_a   = i_num;
                    n_b   = i_den;
                    n_n   = i_num;
                    n_d   = i_den;
                    n_inv = (i_num == '0) || (i_den == '0);
                    n_state = n_inv ? S_DONE : S_TWOS;
                end
            end
            S_TWOS: begin
                // strip common factors of two from all four values
                if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_n = r_n >> 1;
                    n_d = r_d >> 1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_a == '0 || r_b == '0) begin
                    n_rem   = '0;
                    n_q     = r_n;
                    n_cnt   = CNT_LAST;
                    n_state = S_DIVN;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (!sub_borrow) begin
                    n_a = sub_diff[W-1:0];
                end else begin
                    n_b = (~sub_diff[W-1:0]) + W'(1);
                end
            end
            S_DIVN, S_DIVD: begin
                n_rem = sub_borrow ? rem_sh[W-1:0] : sub_diff[W-1:0];
                n_q   = {r_q[W-2:0], ~sub_borrow};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    if (r_state == S_DIVN) begin
                        n_rn    = n_q;
                        n_rem   = '0;
                        n_q     = r_d;
                        n_cnt   = CNT_LAST;
                        n_state = S_DIVD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_ctl.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_sts.idle     = (r_state == S_IDLE);
    assign o_sts.done     = (r_state == S_DONE);
    assign o_sts.invalid  = r_inv;
    assign o_sts.is_whole = !r_inv && (r_q == W'(1));
    assign o_rnum         = r_inv ? '0 : r_rn;
    assign o_rden         = r_inv ? '0 : r_q;

endmodule
